[rtl/pgs_pkg.sv]
`timescale 1ns / 1ps
// Package for the page group statistics table: sizes, beat types, codes and helpers.
// No dependencies; every rtl file imports it.
package pgs_pkg;

    localparam int ADDR_W          = 48;
    localparam int VAL_W           = 32;
    localparam int SUM_W           = 48;
    localparam int SHARE_W         = 17;
    localparam int OFF_W           = 4;

    localparam int NUM_GROUPS      = 4096;
    localparam int HUGEPAGE_SHIFT  = 21;
    localparam int PAGES_PER_GROUP = 8;
    localparam int WINDOW_RADIUS   = 7;

    localparam int IDX_W     = $clog2(NUM_GROUPS);
    localparam int GRP_SHIFT = HUGEPAGE_SHIFT + $clog2(PAGES_PER_GROUP);
    localparam int GRP_W     = ADDR_W - GRP_SHIFT;
    localparam int NB_W      = GRP_W + 2;
    localparam int SHARE_FRAC = 16;

    localparam int DVD_W = SUM_W;
    localparam int DSR_W = VAL_W;
    localparam int CNT_W = $clog2(DVD_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

    localparam logic [VAL_W-1:0] VAL_MAX   = '1;
    localparam logic [VAL_W-1:0] SHARE_MAX = VAL_W'((1 << SHARE_W) - 1);

    localparam logic signed [OFF_W-1:0] OFF_FIRST = OFF_W'(-WINDOW_RADIUS);
    localparam logic signed [OFF_W-1:0] OFF_LAST  = OFF_W'(WINDOW_RADIUS);
    localparam logic signed [OFF_W-1:0] OFF_ZERO  = '0;

    localparam logic STATUS_DONE    = 1'b0;
    localparam logic STATUS_REFUSED = 1'b1;

    // division slots: 0 count, 1 ewma, 2 share, 3 share ewma
    localparam logic [1:0] DSEL_COUNT     = 2'd0;
    localparam logic [1:0] DSEL_EWMA      = 2'd1;
    localparam logic [1:0] DSEL_SHARE     = 2'd2;
    localparam logic [1:0] DSEL_SHARE_EW  = 2'd3;

    typedef enum logic [1:0] {
        OP_UPDATE = 2'd0,
        OP_ADD    = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_QUERY  = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_URD,
        ST_DIV,
        ST_DWAIT,
        ST_UWR,
        ST_QRD,
        ST_QCHK,
        ST_EMIT
    } state_t;

    typedef struct packed {
        op_t               op;
        logic [ADDR_W-1:0] address;
        logic [VAL_W-1:0]  access_count;
        logic [VAL_W-1:0]  access_ewma;
        logic [VAL_W-1:0]  total_accesses;
        logic [VAL_W-1:0]  sample_age;
    } in_item_t;

    typedef struct packed {
        logic                    status;
        logic signed [OFF_W-1:0] window_offset;
        logic                    present;
        logic [VAL_W-1:0]        avg_count;
        logic [VAL_W-1:0]        avg_ewma;
        logic [SHARE_W-1:0]      avg_share;
        logic [SHARE_W-1:0]      avg_share_ewma;
        logic                    last_item;
    } out_item_t;

    typedef struct packed {
        logic [VAL_W-1:0] sample_count;
        logic [VAL_W-1:0] share_samples;
        logic [SUM_W-1:0] sum_count;
        logic [SUM_W-1:0] sum_ewma;
        logic [SUM_W-1:0] sum_share;
        logic [SUM_W-1:0] sum_share_ewma;
    } stats_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DSR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DVD_W-1:0] quotient;
    } div_rsp_t;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

endpackage

[rtl/page_group_stats_table_top.sv]
`timescale 1ns / 1ps
// Top level of the page group statistics table: sequencer, shared divider, output register.
// Depends on pgs_pkg, pgs_div and pgs_ctrl.
//
// Keeps statistics for 4096 page groups (group = address >> 24). Each item is handled alone;
// in_ready is low until its last result beat sits in the output register. One shared
// restoring divider sets the rate: an add, or an update outside the table, needs no division;
// an update needs one division per share (none when total_accesses is zero); a window query
// needs up to four divisions per present neighbour and none per absent one, over 15 beats. The
// reset-all op sweeps the stats memory one entry a cycle. After rst_n the block runs the same
// clearing pass over both memories before it takes its first beat.
module page_group_stats_table_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  pgs_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output pgs_pkg::out_item_t  out_data
);
    import pgs_pkg::*;

    div_req_t  div_req;
    div_rsp_t  div_rsp;
    out_item_t res;
    logic      res_load;
    logic      out_free;
    logic      out_valid_reg;
    out_item_t out_data_reg;

    assign out_free = !out_valid_reg || out_ready;

    pgs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    pgs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_free (out_free),
        .res_load (res_load),
        .res      (res),
        .div_req  (div_req),
        .div_rsp  (div_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
            out_data_reg <= res;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // a result beat never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> (!out_valid_reg || out_ready))
        else $error("result beat overwrote a pending beat");

    // the shared divider is never restarted mid-division
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // an accepted item holds off the next one
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("ready right after accept");

endmodule

[rtl/pgs_div.sv]
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
// Depends on pgs_pkg.
module pgs_div (
    input  logic              clk,
    input  logic              rst_n,
    input  pgs_pkg::div_req_t req,
    output pgs_pkg::div_rsp_t rsp
);
    import pgs_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [DSR_W-1:0] dsr_reg, dsr_next;
    logic [DSR_W:0]   rem_reg, rem_next;
    logic [DSR_W:0]   rem_sh;
    logic             ge;

    always_comb
    begin
        rem_sh    = {rem_reg[DSR_W-1:0], dvd_reg[DVD_W-1]};
        ge        = rem_sh >= {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = req.dividend;
            dsr_next  = req.divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? (rem_sh - {1'b0, dsr_reg}) : rem_sh;
            dvd_next = {dvd_reg[DVD_W-2:0], ge};   // quotient shifts in from the bottom
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = dvd_reg;

endmodule

[rtl/pgs_ctrl.sv]
`timescale 1ns / 1ps
// Sequencer and group table: stats and presence memories, clear sweep, update and
// window walk driving the shared divider. Depends on pgs_pkg.
module pgs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  pgs_pkg::in_item_t   in_data,
    input  logic                out_free,
    output logic                res_load,
    output pgs_pkg::out_item_t  res,
    output pgs_pkg::div_req_t   div_req,
    input  pgs_pkg::div_rsp_t   div_rsp
);
    import pgs_pkg::*;

    state_t                  state_reg, state_next;
    logic                    clr_all_reg;
    logic [IDX_W-1:0]        clr_cnt_reg;
    in_item_t                item_reg;
    logic [GRP_W-1:0]        g_reg;
    logic signed [OFF_W-1:0] off_reg;
    logic                    is_query_reg;
    logic [1:0]              dsel_reg;
    logic                    status_reg;
    logic                    present_reg;
    logic [VAL_W-1:0]        q_reg [0:3];

    stats_t                  stats_mem [0:NUM_GROUPS-1];
    logic                    valid_mem [0:NUM_GROUPS-1];
    stats_t                  stats_rd_reg;
    logic                    valid_rd_reg;

    logic [GRP_W-1:0]        g_in;
    logic                    in_inside;
    logic signed [NB_W-1:0]  nb;
    logic                    nb_out;
    logic [IDX_W-1:0]        rd_addr;
    logic                    accept;
    logic [1:0]              dsel_last;
    logic                    div_zero;
    logic                    last_div;
    logic [VAL_W-1:0]        cap;
    logic [VAL_W-1:0]        q_sat;
    state_t                  after_div;

    logic                    st_we;
    logic [IDX_W-1:0]        st_waddr;
    stats_t                  st_wdata;
    logic                    v_we;
    logic [IDX_W-1:0]        v_waddr;
    logic                    v_wdata;
    stats_t                  upd;
    logic [VAL_W-1:0]        sc_new;

    assign g_in      = in_data.address[ADDR_W-1:GRP_SHIFT];
    assign in_inside = (g_in[GRP_W-1:IDX_W] == '0);
    assign nb        = $signed({2'b00, g_reg}) + NB_W'(off_reg);
    assign nb_out    = nb[NB_W-1] || (nb[NB_W-2:IDX_W] != '0);
    assign rd_addr   = nb[IDX_W-1:0];
    assign accept    = (state_reg == ST_IDLE) && in_valid;
    assign dsel_last = is_query_reg ? DSEL_SHARE_EW : DSEL_EWMA;
    assign last_div  = (dsel_reg == dsel_last);
    assign after_div = is_query_reg ? ST_EMIT : ST_UWR;

    // divider operands per slot
    always_comb
    begin
        div_req.dividend = '0;
        div_req.divisor  = '0;
        cap              = SHARE_MAX;
        if (is_query_reg)
        begin
            unique case (dsel_reg)
                DSEL_COUNT:
                begin
                    div_req.dividend = stats_rd_reg.sum_count;
                    div_req.divisor  = stats_rd_reg.sample_count;
                    cap              = VAL_MAX;
                end
                DSEL_EWMA:
                begin
                    div_req.dividend = stats_rd_reg.sum_ewma;
                    div_req.divisor  = stats_rd_reg.sample_count;
                    cap              = VAL_MAX;
                end
                DSEL_SHARE:
                begin
                    div_req.dividend = stats_rd_reg.sum_share;
                    div_req.divisor  = stats_rd_reg.share_samples;
                end
                default:
                begin
                    div_req.dividend = stats_rd_reg.sum_share_ewma;
                    div_req.divisor  = stats_rd_reg.share_samples;
                end
            endcase
        end
        else
        begin
            div_req.divisor = item_reg.total_accesses;
            if (dsel_reg == DSEL_COUNT)
                div_req.dividend = {item_reg.access_count, {SHARE_FRAC{1'b0}}};
            else
                div_req.dividend = {item_reg.access_ewma, {SHARE_FRAC{1'b0}}};
        end
        div_zero      = (div_req.divisor == '0);
        div_req.start = (state_reg == ST_DIV) && !div_zero;
        q_sat    = (div_rsp.quotient > {{(DVD_W-VAL_W){1'b0}}, cap}) ? cap
                                                                   : div_rsp.quotient[VAL_W-1:0];
    end

    // sample folded into the group's stats
    always_comb
    begin
        sc_new = (stats_rd_reg.sample_count == VAL_MAX) ? VAL_MAX
                                                        : stats_rd_reg.sample_count + 1'b1;
        upd              = stats_rd_reg;
        upd.sample_count = sc_new;
        upd.sum_count    = sat_add(stats_rd_reg.sum_count,
                                   {{(SUM_W-VAL_W){1'b0}}, item_reg.access_count});
        upd.sum_ewma     = sat_add(stats_rd_reg.sum_ewma,
                                   {{(SUM_W-VAL_W){1'b0}}, item_reg.access_ewma});
        if (item_reg.total_accesses != '0)
        begin
            upd.sum_share      = sat_add(stats_rd_reg.sum_share,
                                         {{(SUM_W-VAL_W){1'b0}}, q_reg[0]});
            upd.sum_share_ewma = sat_add(stats_rd_reg.sum_share_ewma,
                                         {{(SUM_W-VAL_W){1'b0}}, q_reg[1]});
            upd.share_samples  = sc_new;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
                if (clr_cnt_reg == '1)
                    state_next = clr_all_reg ? ST_IDLE : ST_EMIT;
            ST_IDLE:
                if (in_valid)
                begin
                    unique case (in_data.op)
                        OP_CLEAR:  state_next = ST_CLEAR;
                        OP_QUERY:  state_next = ST_QRD;
                        OP_UPDATE: state_next = in_inside ? ST_URD : ST_EMIT;
                        default:   state_next = ST_EMIT;
                    endcase
                end
            ST_URD:
                state_next = ST_DIV;
            ST_DIV:
                if (!div_zero)
                    state_next = ST_DWAIT;
                else if (last_div)
                    state_next = after_div;
            ST_DWAIT:
                if (div_rsp.done)
                    state_next = last_div ? after_div : ST_DIV;
            ST_UWR:
                state_next = ST_EMIT;
            ST_QRD:
                state_next = nb_out ? ST_EMIT : ST_QCHK;
            ST_QCHK:
                state_next = valid_rd_reg ? ST_DIV : ST_EMIT;
            ST_EMIT:
                if (out_free)
                    state_next = (is_query_reg && off_reg != OFF_LAST) ? ST_QRD : ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        in_ready      = (state_reg == ST_IDLE);
        res_load      = (state_reg == ST_EMIT) && out_free;
        st_we         = 1'b0;
        st_waddr      = rd_addr;
        st_wdata      = upd;
        v_we          = 1'b0;
        v_waddr       = g_in[IDX_W-1:0];
        v_wdata       = 1'b1;
        if (state_reg == ST_CLEAR)
        begin
            st_we    = 1'b1;
            st_waddr = clr_cnt_reg;
            st_wdata = '0;
            v_we     = clr_all_reg;
            v_waddr  = clr_cnt_reg;
            v_wdata  = 1'b0;
        end
        else if (state_reg == ST_UWR)
        begin
            st_we = 1'b1;
        end
        else if (accept && in_inside && (in_data.op == OP_UPDATE || in_data.op == OP_ADD))
        begin
            v_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
            stats_mem[st_waddr] <= st_wdata;
        if (v_we)
            valid_mem[v_waddr] <= v_wdata;
        stats_rd_reg <= stats_mem[rd_addr];
        valid_rd_reg <= valid_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_all_reg <= 1'b1;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (accept)
                clr_all_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                begin
                    item_reg     <= in_data;
                    g_reg        <= g_in;
                    is_query_reg <= (in_data.op == OP_QUERY);
                    off_reg      <= (in_data.op == OP_QUERY) ? OFF_FIRST : OFF_ZERO;
                    for (int i = 0; i < 4; i++)
                        q_reg[i] <= '0;
                    if (in_data.op == OP_CLEAR)
                    begin
                        status_reg  <= STATUS_DONE;
                        present_reg <= 1'b0;
                    end
                    else
                    begin
                        status_reg  <= in_inside ? STATUS_DONE : STATUS_REFUSED;
                        present_reg <= in_inside;
                    end
                end
            ST_URD:
                dsel_reg <= DSEL_COUNT;
            ST_QRD:
            begin
                for (int i = 0; i < 4; i++)
                    q_reg[i] <= '0;
                status_reg  <= nb_out ? STATUS_REFUSED : STATUS_DONE;
                present_reg <= 1'b0;
            end
            ST_QCHK:
            begin
                present_reg <= valid_rd_reg;
                dsel_reg    <= DSEL_COUNT;
            end
            ST_DIV:
                if (div_zero)
                begin
                    q_reg[dsel_reg] <= '0;
                    dsel_reg        <= dsel_reg + 1'b1;
                end
            ST_DWAIT:
                if (div_rsp.done)
                begin
                    q_reg[dsel_reg] <= q_sat;
                    dsel_reg        <= dsel_reg + 1'b1;
                end
            ST_EMIT:
                if (out_free && is_query_reg)
                    off_reg <= off_reg + 1'b1;
            default:
            begin
            end
        endcase
    end

    // update items keep their shares in q_reg; only query beats show averages
    always_comb
    begin
        res.status         = status_reg;
        res.window_offset  = off_reg;
        res.present        = present_reg;
        res.avg_count      = is_query_reg ? q_reg[0] : '0;
        res.avg_ewma       = is_query_reg ? q_reg[1] : '0;
        res.avg_share      = is_query_reg ? q_reg[2][SHARE_W-1:0] : '0;
        res.avg_share_ewma = is_query_reg ? q_reg[3][SHARE_W-1:0] : '0;
        res.last_item      = !is_query_reg || (off_reg == OFF_LAST);
    end

endmodule

[tb/sv/page_group_stats_table_top_test.sv]
`timescale 1ns / 1ps
// Testbench for page_group_stats_table_top: directed and random beats checked against a
// predictor of the group table built into this file. Depends on pgs_pkg and the rtl.
module page_group_stats_table_top_test;
    import pgs_pkg::*;

    localparam int WATCHDOG_LIMIT = 30000;
    localparam int DRAIN_CYCLES   = 4200;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    in_item_t   in_data = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    out_item_t  out_data;

    page_group_stats_table_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    // predicted table contents
    bit               grp_on     [NUM_GROUPS];
    bit [VAL_W-1:0]   n_samples  [NUM_GROUPS];
    bit [VAL_W-1:0]   n_shares   [NUM_GROUPS];
    bit [SUM_W-1:0]   tot_count  [NUM_GROUPS];
    bit [SUM_W-1:0]   tot_ewma   [NUM_GROUPS];
    bit [SUM_W-1:0]   tot_share  [NUM_GROUPS];
    bit [SUM_W-1:0]   tot_sh_ewma[NUM_GROUPS];

    out_item_t pending_beats[$];
    int        err_count = 0;
    bit        no_gaps = 1'b0;
    int        idle_cycles = 0;

    function automatic bit [SUM_W-1:0] add_capped(bit [SUM_W-1:0] a, bit [SUM_W-1:0] b);
        bit [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

    function automatic bit [SUM_W-1:0] share_q16(bit [VAL_W-1:0] part, bit [VAL_W-1:0] total);
        bit [SUM_W-1:0] q;
        q = {part, 16'b0} / total;
        return (q > SUM_W'(SHARE_MAX)) ? SUM_W'(SHARE_MAX) : q;
    endfunction

    function automatic bit [VAL_W-1:0] mean_of(bit [SUM_W-1:0] sum, bit [VAL_W-1:0] n,
                                               bit [VAL_W-1:0] cap);
        bit [SUM_W-1:0] q;
        if (n == 0)
            return '0;
        q = sum / n;
        return (q > SUM_W'(cap)) ? cap : q[VAL_W-1:0];
    endfunction

    function automatic void clear_table(bit keep_groups);
        for (int i = 0; i < NUM_GROUPS; i++) begin
            if (!keep_groups)
                grp_on[i] = 1'b0;
            n_samples[i] = '0;
            n_shares[i] = '0;
            tot_count[i] = '0;
            tot_ewma[i] = '0;
            tot_share[i] = '0;
            tot_sh_ewma[i] = '0;
        end
    endfunction

    function automatic void predict_beats(in_item_t it);
        out_item_t       r;
        longint unsigned g;
        longint          idx;
        g = it.address >> (HUGEPAGE_SHIFT + 3);
        r = '0;
        r.last_item = 1'b1;
        if (it.op == OP_CLEAR) begin
            clear_table(1'b1);
            pending_beats.push_back(r);
        end else if (it.op == OP_UPDATE || it.op == OP_ADD) begin
            if (g >= NUM_GROUPS) begin
                r.status = STATUS_REFUSED;
            end else begin
                grp_on[g] = 1'b1;
                r.present = 1'b1;
                if (it.op == OP_UPDATE) begin
                    if (n_samples[g] != '1)
                        n_samples[g]++;
                    tot_count[g] = add_capped(tot_count[g], SUM_W'(it.access_count));
                    tot_ewma[g] = add_capped(tot_ewma[g], SUM_W'(it.access_ewma));
                    if (it.total_accesses != 0) begin
                        tot_share[g] = add_capped(tot_share[g],
                            share_q16(it.access_count, it.total_accesses));
                        tot_sh_ewma[g] = add_capped(tot_sh_ewma[g],
                            share_q16(it.access_ewma, it.total_accesses));
                        n_shares[g] = n_samples[g];
                    end
                end
            end
            pending_beats.push_back(r);
        end else begin
            for (int off = -WINDOW_RADIUS; off <= WINDOW_RADIUS; off++) begin
                r = '0;
                idx = longint'(g) + off;
                r.window_offset = OFF_W'(off);
                r.last_item = (off == WINDOW_RADIUS);
                if (idx < 0 || idx >= NUM_GROUPS) begin
                    r.status = STATUS_REFUSED;
                end else if (grp_on[idx]) begin
                    r.present = 1'b1;
                    r.avg_count = mean_of(tot_count[idx], n_samples[idx], VAL_MAX);
                    r.avg_ewma = mean_of(tot_ewma[idx], n_samples[idx], VAL_MAX);
                    r.avg_share = SHARE_W'(mean_of(tot_share[idx], n_shares[idx], SHARE_MAX));
                    r.avg_share_ewma =
                        SHARE_W'(mean_of(tot_sh_ewma[idx], n_shares[idx], SHARE_MAX));
                end
                pending_beats.push_back(r);
            end
        end
    endfunction

    task automatic report(string what, longint unsigned got, longint unsigned want);
        $display("%0t: %s got %0h expected %0h", $realtime, what, got, want);
        err_count++;
    endtask

    task automatic check_beat(out_item_t got);
        out_item_t want;
        if (pending_beats.size() == 0) begin
            report("unexpected beat", 64'(got), 0);
            return;
        end
        want = pending_beats.pop_front();
        if (got.status != want.status) report("status", got.status, want.status);
        if (got.window_offset != want.window_offset)
            report("window_offset", got.window_offset, want.window_offset);
        if (got.present != want.present) report("present", got.present, want.present);
        if (got.avg_count != want.avg_count) report("avg_count", got.avg_count, want.avg_count);
        if (got.avg_ewma != want.avg_ewma) report("avg_ewma", got.avg_ewma, want.avg_ewma);
        if (got.avg_share != want.avg_share) report("avg_share", got.avg_share, want.avg_share);
        if (got.avg_share_ewma != want.avg_share_ewma)
            report("avg_share_ewma", got.avg_share_ewma, want.avg_share_ewma);
        if (got.last_item != want.last_item) report("last_item", got.last_item, want.last_item);
    endtask

    // sink side: random stall before each beat unless no_gaps is set
    initial
    begin
        int stall;
        @(negedge clk);
        forever
        begin
            stall = no_gaps ? 0 : $urandom_range(0, 12);
            if (stall > 0)
            begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
            check_beat(out_data);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("page_group_stats_table_top: mismatch");
            $finish;
        end
    end

    task automatic send_beat(in_item_t it);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 12);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        in_data = it;
        do @(posedge clk); while (!in_ready);
        predict_beats(it);
    endtask

    function automatic logic [ADDR_W-1:0] addr_in_group(int g);
        return {24'(g), 24'($urandom)};
    endfunction

    function automatic in_item_t make_beat(op_t op, int g, logic [VAL_W-1:0] c,
                                           logic [VAL_W-1:0] e, logic [VAL_W-1:0] t,
                                           logic [VAL_W-1:0] age);
        in_item_t it;
        it.op = op;
        it.address = addr_in_group(g);
        it.access_count = c;
        it.access_ewma = e;
        it.total_accesses = t;
        it.sample_age = age;
        return it;
    endfunction

    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        wait (pending_beats.size() == 0);
    endtask

    function automatic logic [VAL_W-1:0] rand_val();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return '1;
            2: return $urandom_range(0, 4096);
            default: return $urandom;
        endcase
    endfunction

    function automatic int rand_group();
        case ($urandom_range(0, 9))
            0, 1: return $urandom_range(NUM_GROUPS - 20, NUM_GROUPS - 1);
            2: return $urandom_range(NUM_GROUPS, NUM_GROUPS + 12);
            3: return $urandom_range(0, NUM_GROUPS - 1);
            default: return $urandom_range(0, 30);
        endcase
    endfunction

    task automatic test_sample_edges();
        send_beat(make_beat(OP_QUERY, 0, '1, '1, '1, '1));   // empty table, low edge
        send_beat(make_beat(OP_UPDATE, 0, '0, '0, '0, '0));
        send_beat(make_beat(OP_UPDATE, 0, '1, '1, '1, '1));
        send_beat(make_beat(OP_UPDATE, 1, 32'h100, 32'h80, '0, 32'h5));   // no share sample
        send_beat(make_beat(OP_UPDATE, 1, '1, 32'h1, 32'h1, '0));         // share saturates
        send_beat(make_beat(OP_UPDATE, 2, 32'h300, 32'h200, 32'h1000, 32'h7));
        send_beat(make_beat(OP_UPDATE, 2, 32'h10, '0, 32'h10, '1));
        send_beat(make_beat(OP_ADD, 4, '1, '1, '1, '1));
        send_beat(make_beat(OP_UPDATE, NUM_GROUPS - 1, 32'h55, 32'haa, 32'h1ff, 32'h3));
        send_beat(make_beat(OP_ADD, NUM_GROUPS - 3, '0, '0, '0, '0));
        send_beat(make_beat(OP_UPDATE, NUM_GROUPS, '1, '1, '1, '1));      // refused
        send_beat(make_beat(OP_ADD, NUM_GROUPS + 1, '0, '0, '0, '0));     // refused
    endtask

    task automatic test_window_edges();
        in_item_t it;
        send_beat(make_beat(OP_QUERY, 1, '0, '0, '0, '0));
        send_beat(make_beat(OP_QUERY, 8, '1, '1, '1, '1));
        send_beat(make_beat(OP_QUERY, NUM_GROUPS - 1, '0, '0, '0, '0));
        send_beat(make_beat(OP_QUERY, NUM_GROUPS + 3, '0, '0, '0, '0));
        it = make_beat(OP_QUERY, 0, '0, '0, '0, '0);
        it.address = '1;                                    // far outside
        send_beat(it);
    endtask

    task automatic test_clear_all();
        in_item_t it;
        it = make_beat(OP_CLEAR, 0, '1, '1, '1, '1);
        it.address = '1;
        send_beat(it);
        send_beat(make_beat(OP_QUERY, 3, '0, '0, '0, '0));
        send_beat(make_beat(OP_UPDATE, 2, 32'h40, 32'h20, 32'h80, 32'h1));
        send_beat(make_beat(OP_QUERY, 2, '0, '0, '0, '0));
    endtask

    task automatic test_random_mix(int count);
        in_item_t it;
        int       pick;
        int       clears = 0;
        for (int n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
                no_gaps = ($urandom_range(0, 3) == 0);
            if (n == count / 2)
                wait_drained();
            pick = $urandom_range(0, 99);
            it = make_beat(OP_UPDATE, rand_group(), rand_val(), rand_val(), rand_val(),
                           rand_val());
            if ($urandom_range(0, 4) == 0)
                it.total_accesses = it.access_count + $urandom_range(0, 3);
            if (pick < 45)
                it.op = OP_UPDATE;
            else if (pick < 60)
                it.op = OP_ADD;
            else if (pick < 62 && clears < 6)
            begin
                it.op = OP_CLEAR;
                clears++;
            end
            else
                it.op = OP_QUERY;
            if ($urandom_range(0, 19) == 0)
                it.address = ADDR_W'({$urandom, $urandom});
            send_beat(it);
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        int waited;
        clear_table(1'b0);
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_sample_edges();
        test_window_edges();
        wait_drained();
        test_clear_all();
        test_random_mix(370);
        @(negedge clk);
        in_valid = 1'b0;
        waited = 0;
        while (pending_beats.size() != 0 && waited < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0 && pending_beats.size() == 0)
            $display("page_group_stats_table_top: match");
        else
            $display("page_group_stats_table_top: mismatch");
        $finish;
    end

endmodule

[filelist.f]
rtl/pgs_pkg.sv
rtl/pgs_div.sv
rtl/pgs_ctrl.sv
rtl/page_group_stats_table_top.sv
tb/sv/page_group_stats_table_top_test.sv
